// ----- hdl/shortest_path_tree_core_assert.svh -----
// Assertion macros for the shortest path tree core.
// Included by modules that carry concurrent assertions.
`ifndef SHORTEST_PATH_TREE_CORE_ASSERT_SVH
`define SHORTEST_PATH_TREE_CORE_ASSERT_SVH
`define SPT_ASSERT_IMPL(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error("lbl failed");
`define SPT_ASSERT_NEXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error("lbl failed");
`endif

// ----- hdl/spt_pkg.sv -----
// Shared types and constants of the shortest path tree core.
// No dependencies.
package spt_pkg;
   localparam int DIST_BITS = 22;
   localparam logic [21:0] DIST_MAX = 22'h3FFFFF;
   localparam logic [2:0] MODE_ADD = 3'd0;
   localparam logic [2:0] MODE_REMOVE = 3'd1;
   localparam logic [2:0] MODE_RUN = 3'd2;
   localparam logic [2:0] MODE_QUERY = 3'd3;
   localparam logic [2:0] MODE_CLEAR = 3'd4;
   localparam logic CSR_DIRECTED = 1'b0;
   localparam logic CSR_VERTEX_COUNT = 1'b1;

   typedef struct packed {
      logic [2:0]  mode;
      logic [5:0]  vertex_a;
      logic [5:0]  vertex_b;
      logic [15:0] weight;
   } req_type;

   typedef struct packed {
      logic        status;
      logic        edge_added;
      logic        reachable;
      logic [21:0] path_distance;
      logic        has_parent;
      logic [5:0]  parent_vertex;
   } rsp_type;
endpackage

// ----- hdl/spt_stream_if.sv -----
// Valid/ready channel carrying one transaction payload.
// Depends on spt_pkg for nothing but is parameterized by payload type.
interface spt_stream_if #(parameter type payload_type = logic) (input logic clock);
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ----- hdl/shortest_path_tree_core.sv -----
// Shortest path tree core: edge matrix RAM with sequenced Dijkstra runs.
// One transaction in flight; next is taken once the result register is free.
// Reset is synchronous, active high; after reset the edge presence RAM is swept
// clear, and no transaction is taken during the sweep.
`include "shortest_path_tree_core_assert.svh"
module shortest_path_tree_core #(
   parameter int MAX_VERTICES = 64,
   parameter int WEIGHT_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   spt_stream_if.sink   req,
   spt_stream_if.source rsp,
   input  logic       csr_write_enable,
   input  logic       csr_index,
   input  logic [6:0] csr_write_data
);
   import spt_pkg::*;
   localparam int VB = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int SB = 2 * VB;
   localparam int SLOTS = 1 << SB;

   localparam logic [3:0] S_CLR = 4'd0, S_IDLE = 4'd1, S_RD = 4'd2, S_WR = 4'd3,
      S_QRY = 4'd4, S_RINIT = 4'd5, S_SEL = 4'd6, S_RLX = 4'd7, S_ECLR = 4'd8,
      S_DONE = 4'd9, S_RD2 = 4'd10;

   logic [3:0] state_ff;
   logic directed_ff;
   logic [6:0] vcount_ff;
   req_type cur_ff;
   logic [SB:0] cnt_ff;
   logic [VB:0] scan_ff;
   logic [VB-1:0] cur_v_ff;
   logic found_ff;
   logic [VB-1:0] best_v_ff;
   logic [21:0] best_d_ff;
   logic best_pv_ff;
   logic [VB-1:0] best_par_ff;
   logic [6:0] n_eff;
   assign n_eff = (vcount_ff > 7'(MAX_VERTICES)) ? 7'(MAX_VERTICES) : vcount_ff;

   // edge RAMs
   logic pres_mem [SLOTS];
   logic [WEIGHT_BITS-1:0] wgt_mem [SLOTS];
   logic pres_q;
   logic [WEIGHT_BITS-1:0] wgt_q;
   logic [SB-1:0] rd_addr, wr_addr;
   logic pres_we, pres_wd, wgt_we;
   logic [WEIGHT_BITS-1:0] wgt_wd;
   always_ff @(posedge clock) begin
      pres_q <= pres_mem[rd_addr];
      wgt_q <= wgt_mem[rd_addr];
      if (pres_we) pres_mem[wr_addr] <= pres_wd;
      if (wgt_we) wgt_mem[wr_addr] <= wgt_wd;
   end

   // vertex RAM: {reached, settled, pvalid, parent, dist}; stale reads masked
   localparam int VW = 3 + VB + 22;
   logic [VW-1:0] vx_mem [MAX_VERTICES];
   logic [VW-1:0] vx_q;
   logic [VB-1:0] vx_ra, vx_wa;
   logic vx_we;
   logic [VW-1:0] vx_wd;
   logic [MAX_VERTICES-1:0] vx_ok_ff;
   always_ff @(posedge clock) begin
      vx_q <= vx_mem[vx_ra];
      if (vx_we) vx_mem[vx_wa] <= vx_wd;
   end
   logic vq_ok_ff;
   always_ff @(posedge clock) vq_ok_ff <= vx_ok_ff[vx_ra];
   logic [VW-1:0] vx_r;
   assign vx_r = vq_ok_ff ? vx_q : '0;
   logic v_reached, v_settled, v_pvalid;
   logic [VB-1:0] v_parent;
   logic [21:0] v_dist;
   assign {v_reached, v_settled, v_pvalid, v_parent, v_dist} = vx_r;

   logic rsp_valid_ff;
   rsp_type rsp_ff, rsp_in;
   logic bad_a, bad_b;
   assign bad_a = {1'b0, cur_ff.vertex_a} >= n_eff;
   assign bad_b = {1'b0, cur_ff.vertex_b} >= n_eff;
   logic [SB-1:0] ab, ba;
   assign ab = {cur_ff.vertex_a[VB-1:0], cur_ff.vertex_b[VB-1:0]};
   assign ba = {cur_ff.vertex_b[VB-1:0], cur_ff.vertex_a[VB-1:0]};

   // relax pipeline: address issued at scan, data back in the following cycle
   logic rl_v_ff;
   logic [VB-1:0] rl_idx_ff;
   logic [21:0] cur_d_ff;
   logic [32:0] sum;
   assign sum = 33'(cur_d_ff) + 33'(wgt_q);
   logic [21:0] cand;
   assign cand = (sum > 33'(DIST_MAX)) ? DIST_MAX : sum[21:0];

   assign req.ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.payload = rsp_ff;

   always_comb begin
      rd_addr = ab;
      wr_addr = ab;
      pres_we = 1'b0; pres_wd = 1'b0; wgt_we = 1'b0;
      wgt_wd = WEIGHT_BITS'(cur_ff.weight);
      vx_ra = cur_ff.vertex_a[VB-1:0];
      vx_wa = rl_idx_ff; vx_we = 1'b0; vx_wd = '0;
      rsp_in = '0;
      unique case (state_ff)
         S_CLR, S_ECLR: begin
            pres_we = 1'b1;
            wr_addr = cnt_ff[SB-1:0];
         end
         S_RD: begin
            rsp_in.status = (cur_ff.mode == MODE_QUERY) ? bad_a : (bad_a || bad_b);
         end
         S_WR: begin
            rsp_in.edge_added = (cur_ff.mode == MODE_ADD) && !pres_q;
            if (cur_ff.mode == MODE_ADD) begin
               pres_we = 1'b1; pres_wd = 1'b1; wgt_we = 1'b1;
            end else if (pres_q) begin
               pres_we = 1'b1;
            end
         end
         S_RD2: begin
            wr_addr = ba;
            pres_we = 1'b1;
            pres_wd = (cur_ff.mode == MODE_ADD);
            wgt_we = (cur_ff.mode == MODE_ADD);
         end
         S_RINIT: begin
            rsp_in.status = bad_a;
            if (!bad_a) begin
               vx_we = 1'b1;
               vx_wa = cur_ff.vertex_a[VB-1:0];
               vx_wd = {1'b1, {(VW-1){1'b0}}};
            end
         end
         S_SEL: begin
            vx_ra = scan_ff[VB-1:0];
         end
         S_DONE: begin
            vx_we = 1'b1;
            vx_wa = best_v_ff;
            vx_wd = {1'b1, 1'b1, best_pv_ff, best_par_ff, best_d_ff};
         end
         S_RLX: begin
            rd_addr = {cur_v_ff, scan_ff[VB-1:0]};
            vx_ra = scan_ff[VB-1:0];
            if (rl_v_ff && pres_q && (!v_reached || cand < v_dist)) begin
               vx_we = 1'b1;
               vx_wd = {1'b1, v_settled, 1'b1, cur_v_ff, cand};
            end
         end
         S_QRY: begin
            if (v_reached) begin
               rsp_in.reachable = 1'b1;
               rsp_in.path_distance = v_dist;
               rsp_in.has_parent = v_pvalid;
               rsp_in.parent_vertex = v_pvalid ? 6'(v_parent) : 6'd0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vx_ok_ff <= '0;
      end else if (state_ff == S_RINIT && !bad_a) begin
         vx_ok_ff <= MAX_VERTICES'(1) << vx_wa;
      end else if (vx_we) begin
         vx_ok_ff[vx_wa] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
         cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
         directed_ff <= 1'b0;
         vcount_ff <= 7'd64;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_DIRECTED: directed_ff <= csr_write_data[0];
               CSR_VERTEX_COUNT: vcount_ff <= csr_write_data;
            endcase
         end
         if (rsp_valid_ff && rsp.ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_CLR, S_ECLR: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff[SB-1:0] == SB'(SLOTS - 1)) begin
                  if (state_ff == S_CLR) state_ff <= S_IDLE;
                  else begin
                     rsp_ff <= '0; rsp_valid_ff <= 1'b1; state_ff <= S_IDLE;
                  end
               end
            end
            S_IDLE: if (req.valid && req.ready) begin
               cur_ff <= req.payload;
               priority case (req.payload.mode)
                  MODE_ADD, MODE_REMOVE: state_ff <= S_RD;
                  MODE_RUN: state_ff <= S_RINIT;
                  MODE_QUERY: state_ff <= S_RD;
                  MODE_CLEAR: begin cnt_ff <= '0; state_ff <= S_ECLR; end
                  default: begin rsp_ff <= '0; rsp_valid_ff <= 1'b1; end
               endcase
            end
            S_RD: begin
               if (rsp_in.status) begin
                  rsp_ff <= rsp_in; rsp_valid_ff <= 1'b1; state_ff <= S_IDLE;
               end else if (cur_ff.mode == MODE_QUERY) state_ff <= S_QRY;
               else state_ff <= S_WR;
            end
            S_WR: begin
               rsp_ff <= rsp_in;
               if (!directed_ff && (cur_ff.mode == MODE_ADD || pres_q))
                  state_ff <= S_RD2;
               else begin
                  rsp_valid_ff <= 1'b1; state_ff <= S_IDLE;
               end
            end
            S_RD2: begin
               rsp_valid_ff <= 1'b1; state_ff <= S_IDLE;
            end
            S_QRY: begin
               rsp_ff <= rsp_in; rsp_valid_ff <= 1'b1; state_ff <= S_IDLE;
            end
            S_RINIT: begin
               if (bad_a) begin
                  rsp_ff <= rsp_in; rsp_valid_ff <= 1'b1; state_ff <= S_IDLE;
               end else begin
                  scan_ff <= '0; found_ff <= 1'b0;
                  state_ff <= S_SEL;
               end
            end
            S_SEL: begin
               scan_ff <= scan_ff + 1'b1;
               if (scan_ff != '0 && v_reached && !v_settled &&
                   (!found_ff || v_dist < best_d_ff)) begin
                  found_ff <= 1'b1;
                  best_v_ff <= VB'(scan_ff - 1'b1);
                  best_d_ff <= v_dist;
                  best_pv_ff <= v_pvalid;
                  best_par_ff <= v_parent;
               end
               if (scan_ff == (VB+1)'(n_eff)) begin
                  if (!found_ff && !(v_reached && !v_settled)) begin
                     rsp_ff <= '0; rsp_valid_ff <= 1'b1; state_ff <= S_IDLE;
                  end else state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               cur_v_ff <= best_v_ff; cur_d_ff <= best_d_ff;
               scan_ff <= '0; rl_v_ff <= 1'b0;
               state_ff <= S_RLX;
            end
            S_RLX: begin
               rl_v_ff <= scan_ff < (VB+1)'(n_eff);
               rl_idx_ff <= scan_ff[VB-1:0];
               if (scan_ff == (VB+1)'(n_eff)) begin
                  scan_ff <= '0; found_ff <= 1'b0; state_ff <= S_SEL;
               end else scan_ff <= scan_ff + 1'b1;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   `SPT_ASSERT_IMPL(a_rsp_one, clock, reset, !(req.valid && req.ready && rsp_valid_ff))
   `SPT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid_ff && !rsp.ready, rsp_valid_ff)
   `SPT_ASSERT_IMPL(a_ready_idle, clock, reset, !req.ready || state_ff == S_IDLE)
endmodule

// ----- tb/sv/shortest_path_tree_core_tb.sv -----
// Testbench for the shortest path tree core: drives add, remove, run, query and clear
// transactions and checks each response against a built-in path predictor.
// Depends on spt_pkg, spt_stream_if and shortest_path_tree_core.
`timescale 1ns / 100ps
module shortest_path_tree_core_tb;
   import spt_pkg::*;

   localparam int NV = 64;
   localparam logic [21:0] SAT = 22'h3FFFFF;
   localparam logic [2:0] MODE_SPARE_LO = 3'd5;
   localparam logic [2:0] MODE_SPARE_HI = 3'd7;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic csr_index = CSR_DIRECTED;
   logic [6:0] csr_write_data = '0;

   spt_stream_if #(.payload_type(req_type)) req_if (clock);
   spt_stream_if #(.payload_type(rsp_type)) rsp_if (clock);

   shortest_path_tree_core u_dut (
      .clock(clock), .reset(reset), .req(req_if.sink), .rsp(rsp_if.source),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // predictor state
   bit edge_on [NV*NV];
   logic [15:0] edge_w [NV*NV];
   logic [21:0] path_d [NV];
   logic [5:0] par [NV];
   bit par_ok [NV];
   bit reached [NV];
   bit settled [NV];
   bit graph_directed;
   int active_n;

   req_type pending_reqs[$];
   rsp_type expected_rsps[$];
   int errors = 0;
   int gap_left = 0;
   int stall_left = 0;
   bit hold_sender = 1'b0;
   bit req_taken = 1'b0;
   bit rsp_taken = 1'b0;

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      errors++;
   endtask

   function automatic void run_paths(input int src);
      int cur;
      bit found;
      logic [22:0] sum;
      logic [21:0] cand;
      for (int i = 0; i < NV; i++) begin
         path_d[i] = '0; par[i] = '0; par_ok[i] = 0; reached[i] = 0; settled[i] = 0;
      end
      reached[src] = 1;
      forever begin
         cur = 0;
         found = 0;
         for (int i = 0; i < active_n; i++)
            if (reached[i] && !settled[i] && (!found || path_d[i] < path_d[cur])) begin
               cur = i;
               found = 1;
            end
         if (!found) break;
         settled[cur] = 1;
         for (int v = 0; v < active_n; v++) begin
            if (!edge_on[cur*NV+v]) continue;
            sum = {1'b0, path_d[cur]} + {7'd0, edge_w[cur*NV+v]};
            cand = sum > {1'b0, SAT} ? SAT : sum[21:0];
            if (!reached[v] || cand < path_d[v]) begin
               reached[v] = 1;
               path_d[v] = cand;
               par[v] = cur[5:0];
               par_ok[v] = 1;
            end
         end
      end
   endfunction

   function automatic rsp_type predict_path_rsp(input req_type t);
      rsp_type r;
      int a, b;
      r = '0;
      a = t.vertex_a;
      b = t.vertex_b;
      case (t.mode)
         MODE_ADD: begin
            if (a >= active_n || b >= active_n) r.status = 1'b1;
            else begin
               r.edge_added = !edge_on[a*NV+b];
               edge_on[a*NV+b] = 1;
               edge_w[a*NV+b] = t.weight;
               if (!graph_directed) begin
                  edge_on[b*NV+a] = 1;
                  edge_w[b*NV+a] = t.weight;
               end
            end
         end
         MODE_REMOVE: begin
            if (a >= active_n || b >= active_n) r.status = 1'b1;
            else if (edge_on[a*NV+b]) begin
               edge_on[a*NV+b] = 0;
               if (!graph_directed) edge_on[b*NV+a] = 0;
            end
         end
         MODE_RUN: begin
            if (a >= active_n) r.status = 1'b1;
            else run_paths(a);
         end
         MODE_QUERY: begin
            if (a >= active_n) r.status = 1'b1;
            else if (reached[a]) begin
               r.reachable = 1'b1;
               r.path_distance = path_d[a];
               r.has_parent = par_ok[a];
               r.parent_vertex = par_ok[a] ? par[a] : 6'd0;
            end
         end
         MODE_CLEAR: begin
            for (int i = 0; i < NV*NV; i++) edge_on[i] = 0;
         end
         default: ;
      endcase
      return r;
   endfunction

   initial begin
      req_if.valid = 1'b0;
      req_if.payload = '0;
      rsp_if.ready = 1'b0;
   end

   always @(posedge clock) begin
      req_taken = !reset && req_if.valid && req_if.ready;
      rsp_taken = !reset && rsp_if.valid && rsp_if.ready;
   end

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (req_taken) begin
         expected_rsps.push_back(predict_path_rsp(req_if.payload));
         void'(pending_reqs.pop_front());
         gap_left = $urandom_range(0, 3) == 0 ? $urandom_range(0, 19) : 0;
         if (gap_left == 0 && pending_reqs.size() > 0 && !hold_sender) begin
            req_if.payload <= pending_reqs[0];
         end else begin
            req_if.valid <= 1'b0;
         end
      end else if (!req_if.valid) begin
         if (gap_left > 0) begin
            gap_left--;
         end else if (pending_reqs.size() > 0 && !hold_sender) begin
            req_if.payload <= pending_reqs[0];
            req_if.valid <= 1'b1;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_rsps.size() == 0) begin
            report("unexpected transaction", 0, 0);
         end else begin
            rsp_type w;
            w = expected_rsps.pop_front();
            if (rsp_if.payload.status !== w.status)
               report("status", rsp_if.payload.status, w.status);
            if (rsp_if.payload.edge_added !== w.edge_added)
               report("edge_added", rsp_if.payload.edge_added, w.edge_added);
            if (rsp_if.payload.reachable !== w.reachable)
               report("reachable", rsp_if.payload.reachable, w.reachable);
            if (rsp_if.payload.path_distance !== w.path_distance)
               report("path_distance", rsp_if.payload.path_distance, w.path_distance);
            if (rsp_if.payload.has_parent !== w.has_parent)
               report("has_parent", rsp_if.payload.has_parent, w.has_parent);
            if (rsp_if.payload.parent_vertex !== w.parent_vertex)
               report("parent_vertex", rsp_if.payload.parent_vertex, w.parent_vertex);
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (rsp_taken) begin
         stall_left = $urandom_range(0, 3) == 0 ? $urandom_range(0, 19) : 0;
         if (stall_left > 0) rsp_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   function automatic req_type make_req(input logic [2:0] m, input int a, input int b,
                                        input int w);
      req_type t;
      t.mode = m;
      t.vertex_a = a[5:0];
      t.vertex_b = b[5:0];
      t.weight = w[15:0];
      return t;
   endfunction

   task automatic drain();
      while (pending_reqs.size() > 0 || expected_rsps.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input int value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value[6:0];
      @(negedge clock);
      csr_write_enable <= 1'b0;
      if (idx == CSR_DIRECTED) graph_directed = value[0];
      else active_n = value[6:0] > NV ? NV : value[6:0];
   endtask

   // random graph phase on the first n vertices; mostly valid indices
   task automatic random_phase(input int count, input int n);
      int a, b, pick, w;
      for (int k = 0; k < count; k++) begin
         a = $urandom_range(0, 15) == 0 ? $urandom_range(0, 63) : $urandom_range(0, n - 1);
         b = $urandom_range(0, 15) == 0 ? $urandom_range(0, 63) : $urandom_range(0, n - 1);
         w = $urandom_range(0, 7) == 0 ? $urandom_range(65000, 65535) : $urandom_range(0, 65535);
         pick = $urandom_range(0, 99);
         if (pick < 35) pending_reqs.push_back(make_req(MODE_ADD, a, b, w));
         else if (pick < 45) pending_reqs.push_back(make_req(MODE_REMOVE, a, b, 0));
         else if (pick < 53) pending_reqs.push_back(make_req(MODE_RUN, a, b, w));
         else if (pick < 95) pending_reqs.push_back(make_req(MODE_QUERY, a, b, w));
         else if (pick < 97) pending_reqs.push_back(make_req(MODE_CLEAR, a, b, w));
         else pending_reqs.push_back(
            make_req(3'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI)), a, b, w));
      end
   endtask

   initial begin
      graph_directed = 0;
      active_n = NV;
      for (int i = 0; i < NV*NV; i++) begin
         edge_on[i] = 0;
         edge_w[i] = '0;
      end
      for (int i = 0; i < NV; i++) begin
         path_d[i] = '0; par[i] = '0; par_ok[i] = 0; reached[i] = 0; settled[i] = 0;
      end
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_csr(CSR_DIRECTED, 1);
      write_csr(CSR_VERTEX_COUNT, 64);
      pending_reqs.push_back(make_req(MODE_QUERY, 0, 0, 0));
      pending_reqs.push_back(make_req(MODE_ADD, 0, 63, 65535));
      pending_reqs.push_back(make_req(MODE_ADD, 63, 62, 65535));
      pending_reqs.push_back(make_req(MODE_ADD, 0, 63, 0));
      pending_reqs.push_back(make_req(MODE_ADD, 63, 0, 21845));
      pending_reqs.push_back(make_req(MODE_REMOVE, 5, 6, 0));
      pending_reqs.push_back(make_req(MODE_RUN, 0, 0, 0));
      pending_reqs.push_back(make_req(MODE_QUERY, 62, 0, 0));
      pending_reqs.push_back(make_req(MODE_QUERY, 5, 0, 0));
      pending_reqs.push_back(make_req(MODE_QUERY, 0, 0, 0));
      pending_reqs.push_back(make_req(MODE_REMOVE, 0, 63, 0));
      pending_reqs.push_back(make_req(MODE_QUERY, 63, 0, 0));
      pending_reqs.push_back(make_req(MODE_SPARE_LO, 63, 63, 65535));
      pending_reqs.push_back(make_req(MODE_SPARE_HI, 42, 21, 43690));
      pending_reqs.push_back(make_req(MODE_CLEAR, 0, 0, 0));
      pending_reqs.push_back(make_req(MODE_RUN, 63, 0, 0));
      pending_reqs.push_back(make_req(MODE_QUERY, 63, 0, 0));
      drain();

      // chain of maximum-weight edges over a small graph
      write_csr(CSR_VERTEX_COUNT, 8);
      for (int i = 0; i < 7; i++) pending_reqs.push_back(make_req(MODE_ADD, i, i + 1, 65535));
      pending_reqs.push_back(make_req(MODE_ADD, 8, 1, 1));
      pending_reqs.push_back(make_req(MODE_RUN, 8, 0, 0));
      pending_reqs.push_back(make_req(MODE_RUN, 0, 0, 0));
      pending_reqs.push_back(make_req(MODE_QUERY, 7, 0, 0));
      pending_reqs.push_back(make_req(MODE_QUERY, 8, 0, 0));
      drain();
      write_csr(CSR_DIRECTED, 0);
      write_csr(CSR_VERTEX_COUNT, 1);
      pending_reqs.push_back(make_req(MODE_ADD, 0, 0, 3));
      pending_reqs.push_back(make_req(MODE_ADD, 0, 1, 3));
      pending_reqs.push_back(make_req(MODE_RUN, 0, 0, 0));
      pending_reqs.push_back(make_req(MODE_QUERY, 0, 0, 0));
      drain();

      write_csr(CSR_VERTEX_COUNT, 6);
      random_phase(200, 6);
      repeat (300) @(posedge clock);
      hold_sender = 1'b1;
      while (expected_rsps.size() > 0 || req_if.valid) @(posedge clock);
      hold_sender = 1'b0;
      drain();
      write_csr(CSR_DIRECTED, 1);
      write_csr(CSR_VERTEX_COUNT, 10);
      random_phase(200, 10);
      drain();
      write_csr(CSR_DIRECTED, 0);
      write_csr(CSR_VERTEX_COUNT, 100);
      random_phase(160, 12);
      drain();
      write_csr(CSR_VERTEX_COUNT, 64);
      random_phase(60, 64);
      drain();

      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #200_000_000;
      $display("TEST FAILED");
      $finish;
   end
endmodule
